// ===== hdl/bpa_pkg.sv =====
package bpa_pkg;

  // default sizing of the page table
  localparam int DEF_NUM_PAGES   = 1024;
  localparam int DEF_PAGE_SHIFT  = 12;
  localparam int DEF_ORDER_LIMIT = 10;
  localparam int MAX_ORDER_RST   = 10;

  // fixed field widths
  localparam int SIZE_W  = 32;
  localparam int ADDR_W  = 22;
  localparam int END_W   = 23;
  localparam int ORDER_W = 4;

  // request codes
  localparam logic [1:0] REQ_RESERVE = 2'd0;
  localparam logic [1:0] REQ_BUILD   = 2'd1;
  localparam logic [1:0] REQ_ALLOC   = 2'd2;
  localparam logic [1:0] REQ_FREE    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFREE  = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  // sequencer states
  typedef enum logic [32:0] {
    S_CLR  = 33'd1 << 0,
    S_IDLE = 33'd1 << 1,
    S_RES  = 33'd1 << 2,
    S_BS   = 33'd1 << 3,
    S_BT   = 33'd1 << 4,
    S_BE   = 33'd1 << 5,
    S_BF   = 33'd1 << 6,
    S_BC   = 33'd1 << 7,
    S_BZ   = 33'd1 << 8,
    S_A0   = 33'd1 << 9,
    S_A1   = 33'd1 << 10,
    S_A2   = 33'd1 << 11,
    S_A3   = 33'd1 << 12,
    S_A4   = 33'd1 << 13,
    S_A5   = 33'd1 << 14,
    S_R0   = 33'd1 << 15,
    S_R1   = 33'd1 << 16,
    S_R2   = 33'd1 << 17,
    S_R3   = 33'd1 << 18,
    S_R4   = 33'd1 << 19,
    S_R4B  = 33'd1 << 20,
    S_R5   = 33'd1 << 21,
    S_R6   = 33'd1 << 22,
    S_DONE = 33'd1 << 23,
    S_U0   = 33'd1 << 24,
    S_U1   = 33'd1 << 25,
    S_U2   = 33'd1 << 26,
    S_U3   = 33'd1 << 27,
    S_U4   = 33'd1 << 28,
    S_F0   = 33'd1 << 29,
    S_F1   = 33'd1 << 30,
    S_B0   = 33'd1 << 31,
    S_B1   = 33'd1 << 32
  } state_t;

endpackage

// ===== hdl/bpa_if.sv =====
interface bpa_req_if import bpa_pkg::*;;
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic [SIZE_W-1:0]   size_bytes;
  logic [ADDR_W-1:0]   start_addr;
  logic [END_W-1:0]    end_addr;

  modport source (output valid, req_type, size_bytes, start_addr, end_addr, input ready);
  modport sink (input valid, req_type, size_bytes, start_addr, end_addr, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*;;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [ADDR_W-1:0]   block_addr;
  logic [ORDER_W-1:0]  block_order;

  modport source (output valid, status, block_addr, block_order, input ready);
  modport sink (input valid, status, block_addr, block_order, output ready);
endinterface

// ===== hdl/bpa_ram.sv =====
module bpa_ram import bpa_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = DEF_NUM_PAGES
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bpa_ctrl.sv =====
module bpa_ctrl import bpa_pkg::*; #(
  parameter int NUM_PAGES   = DEF_NUM_PAGES,
  parameter int PAGE_SHIFT  = DEF_PAGE_SHIFT,
  parameter int ORDER_LIMIT = DEF_ORDER_LIMIT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  bpa_req_if.sink                               in_ch,
  bpa_rsp_if.source                             out_ch,
  input  logic                                  cfg_we,
  input  logic [ORDER_W-1:0]                    cfg_wdata,
  output logic                                  tag_we,
  output logic [$clog2(NUM_PAGES)-1:0]          tag_waddr,
  output logic [$clog2(2*ORDER_LIMIT+4)-1:0]    tag_wdata,
  output logic [$clog2(NUM_PAGES)-1:0]          tag_raddr,
  input  logic [$clog2(2*ORDER_LIMIT+4)-1:0]    tag_rdata,
  output logic                                  link_we,
  output logic [$clog2(NUM_PAGES)-1:0]          link_waddr,
  output logic [2*$clog2(NUM_PAGES+1)-1:0]      link_wdata,
  output logic [$clog2(NUM_PAGES)-1:0]          link_raddr,
  input  logic [2*$clog2(NUM_PAGES+1)-1:0]      link_rdata
);

  localparam int CW = $clog2(NUM_PAGES + 1);
  localparam int AW = $clog2(NUM_PAGES);
  localparam int OW = $clog2(ORDER_LIMIT + 1);
  localparam int TW = $clog2(2 * ORDER_LIMIT + 4);
  localparam int LG = $clog2(NUM_PAGES + 1) - 1;

  localparam logic [CW-1:0] NIL      = CW'(NUM_PAGES);
  localparam logic [CW-1:0] LAST_PG  = CW'(NUM_PAGES - 1);
  localparam logic [TW-1:0] TAG_RES  = TW'(1);
  localparam logic [TW-1:0] TAG_FREE0 = TW'(2);
  localparam logic [TW-1:0] TAG_ALLOC0 = TW'(ORDER_LIMIT + 3);
  localparam logic [TW-1:0] TAG_ALLOCN = TW'(2 * ORDER_LIMIT + 3);

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [OW-1:0] maxo_r, maxo_nxt;
  logic [CW-1:0] pg_r, pg_nxt, e_r, e_nxt, blk_r, blk_nxt, pb_r, pb_nxt;
  logic [CW-1:0] sp_r, sp_nxt, b_r, b_nxt, pr_r, pr_nxt, nx_r, nx_nxt;
  logic [OW-1:0] so_r, so_nxt, o_r, o_nxt, want_r, want_nxt, c_r, c_nxt;
  logic [CW-1:0] head_r [ORDER_LIMIT+1];
  logic [CW-1:0] head_nxt [ORDER_LIMIT+1];
  logic [CW-1:0] tail_r [ORDER_LIMIT+1];
  logic [CW-1:0] tail_nxt [ORDER_LIMIT+1];
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [ADDR_W-1:0] start_r, start_nxt;
  logic [1:0] res_st_r, res_st_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [OW-1:0] res_ord_r, res_ord_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_st_r, out_st_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [OW-1:0] out_ord_r, out_ord_nxt;

  logic [CW-1:0] rd_next, rd_prev;
  logic [31:0] lo_pg, hi_pg, m_pages, bx, start_pg;
  logic [OW-1:0] want_c, found_c, best_o;
  logic hit_c;

  assign rd_next = link_rdata[2*CW-1:CW];
  assign rd_prev = link_rdata[CW-1:0];

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.block_addr  = out_addr_r;
  assign out_ch.block_order = ORDER_W'(out_ord_r);

  // page range of a reserve transaction
  assign lo_pg = 32'(in_ch.start_addr) >> PAGE_SHIFT;
  assign hi_pg = (32'(in_ch.end_addr) + (32'd1 << PAGE_SHIFT) - 32'd1) >> PAGE_SHIFT;

  // page index of a freed address, buddy of the current block
  assign start_pg = 32'(start_r) >> PAGE_SHIFT;
  assign bx       = 32'(pg_r) ^ (32'd1 << o_r);

  // requested order: smallest k with 2^k pages covering the size, capped
  assign m_pages = (size_r == '0) ? 32'd0 : ((size_r - 32'd1) >> PAGE_SHIFT);
  always_comb begin
    want_c = maxo_r;
    for (int k = ORDER_LIMIT; k >= 0; k--) begin
      if ((k <= 32'(maxo_r)) && ((m_pages >> k) == 32'd0)) begin
        want_c = OW'(k);
      end
    end
  end

  // smallest nonempty list at or above the requested order
  always_comb begin
    found_c = '0;
    hit_c   = 1'b0;
    for (int k = ORDER_LIMIT; k >= 0; k--) begin
      if ((k >= 32'(want_r)) && (k <= 32'(maxo_r)) && (head_r[k] < NIL)) begin
        found_c = OW'(k);
        hit_c   = 1'b1;
      end
    end
  end

  // largest aligned block that fits the rest of the run
  always_comb begin
    best_o = '0;
    for (int k = 0; k <= ORDER_LIMIT; k++) begin
      if ((k <= 32'(maxo_r)) && ((32'(pg_r) & ((32'd1 << k) - 32'd1)) == 32'd0) &&
          ((32'(pg_r) + (32'd1 << k)) <= 32'(e_r))) begin
        best_o = OW'(k);
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    maxo_nxt  = maxo_r;
    pg_nxt    = pg_r;
    e_nxt     = e_r;
    blk_nxt   = blk_r;
    pb_nxt    = pb_r;
    sp_nxt    = sp_r;
    b_nxt     = b_r;
    pr_nxt    = pr_r;
    nx_nxt    = nx_r;
    so_nxt    = so_r;
    o_nxt     = o_r;
    want_nxt  = want_r;
    c_nxt     = c_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    size_nxt  = size_r;
    start_nxt = start_r;
    res_st_nxt   = res_st_r;
    res_addr_nxt = res_addr_r;
    res_ord_nxt  = res_ord_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_addr_nxt  = out_addr_r;
    out_ord_nxt   = out_ord_r;
    tag_we     = 1'b0;
    tag_waddr  = pg_r[AW-1:0];
    tag_wdata  = '0;
    tag_raddr  = pg_r[AW-1:0];
    link_we    = 1'b0;
    link_waddr = sp_r[AW-1:0];
    link_wdata = '0;
    link_raddr = sp_r[AW-1:0];

    // result taken downstream
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // clearing pass over the tag memory after reset
      S_CLR: begin
        tag_we = 1'b1;
        if (pg_r == LAST_PG) begin
          pg_nxt    = '0;
          state_nxt = S_IDLE;
        end else begin
          pg_nxt = pg_r + CW'(1);
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          size_nxt     = in_ch.size_bytes;
          start_nxt    = in_ch.start_addr;
          res_st_nxt   = ST_OK;
          res_addr_nxt = '0;
          res_ord_nxt  = '0;
          case (in_ch.req_type)
            REQ_RESERVE: begin
              pg_nxt    = (lo_pg > 32'(NUM_PAGES)) ? NIL : CW'(lo_pg);
              e_nxt     = (hi_pg > 32'(NUM_PAGES)) ? NIL : CW'(hi_pg);
              state_nxt = S_RES;
            end
            REQ_BUILD: begin
              if (32'(maxo_r) > LG) begin
                maxo_nxt = OW'(LG);
              end
              for (int k = 0; k <= ORDER_LIMIT; k++) begin
                head_nxt[k] = NIL;
                tail_nxt[k] = NIL;
              end
              pg_nxt    = '0;
              state_nxt = S_BS;
            end
            REQ_ALLOC: state_nxt = S_A0;
            default:   state_nxt = S_R0;
          endcase
        end
      end
      // reserve: tag each page of the range
      S_RES: begin
        if (pg_r < e_r) begin
          tag_we    = 1'b1;
          tag_wdata = TAG_RES;
          pg_nxt    = pg_r + CW'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end
      // build: find the start of a free run
      S_BS: begin
        if (pg_r == NIL) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_BT;
        end
      end
      S_BT: begin
        if (tag_rdata == TAG_RES) begin
          pg_nxt    = pg_r + CW'(1);
          state_nxt = S_BS;
        end else begin
          e_nxt     = pg_r + CW'(1);
          state_nxt = S_BE;
        end
      end
      // build: find the end of the run
      S_BE: begin
        tag_raddr = e_r[AW-1:0];
        if (e_r == NIL) begin
          state_nxt = S_BC;
        end else begin
          state_nxt = S_BF;
        end
      end
      S_BF: begin
        if (tag_rdata == TAG_RES) begin
          state_nxt = S_BC;
        end else begin
          e_nxt     = e_r + CW'(1);
          state_nxt = S_BE;
        end
      end
      // build: carve one block and append it to its list
      S_BC: begin
        if (pg_r >= e_r) begin
          state_nxt = S_BS;
        end else begin
          tag_we    = 1'b1;
          tag_wdata = TAG_FREE0 + TW'(best_o);
          so_nxt    = best_o;
          sp_nxt    = pg_r;
          pg_nxt    = pg_r + CW'(1);
          blk_nxt   = CW'(32'(pg_r) + (32'd1 << best_o));
          ret_nxt   = S_BZ;
          state_nxt = S_B0;
        end
      end
      // build: clear the tags inside the block
      S_BZ: begin
        if (pg_r < blk_r) begin
          tag_we    = 1'b1;
          tag_wdata = '0;
          pg_nxt    = pg_r + CW'(1);
        end else begin
          state_nxt = S_BC;
        end
      end
      // allocate
      S_A0: begin
        want_nxt  = want_c;
        state_nxt = S_A1;
      end
      S_A1: begin
        if (!hit_c) begin
          res_st_nxt = ST_NOFREE;
          state_nxt  = S_DONE;
        end else begin
          c_nxt     = found_c;
          state_nxt = S_A2;
        end
      end
      S_A2: begin
        if (c_r > want_r) begin
          sp_nxt  = head_r[c_r];
          so_nxt  = c_r;
          ret_nxt = S_A3;
        end else begin
          sp_nxt  = head_r[want_r];
          so_nxt  = want_r;
          ret_nxt = S_A5;
        end
        state_nxt = S_U0;
      end
      // split: upper half goes on the lower list first
      S_A3: begin
        pb_nxt    = sp_r;
        so_nxt    = c_r - OW'(1);
        sp_nxt    = CW'(32'(sp_r) + (32'd1 << (c_r - OW'(1))));
        tag_we    = 1'b1;
        tag_waddr = sp_nxt[AW-1:0];
        tag_wdata = TAG_FREE0 + TW'(c_r - OW'(1));
        ret_nxt   = S_A4;
        state_nxt = S_F0;
      end
      S_A4: begin
        sp_nxt    = pb_r;
        tag_we    = 1'b1;
        tag_waddr = pb_r[AW-1:0];
        tag_wdata = TAG_FREE0 + TW'(so_r);
        c_nxt     = c_r - OW'(1);
        ret_nxt   = S_A2;
        state_nxt = S_F0;
      end
      S_A5: begin
        tag_we       = 1'b1;
        tag_waddr    = sp_r[AW-1:0];
        tag_wdata    = TAG_ALLOC0 + TW'(want_r);
        res_addr_nxt = ADDR_W'(32'(sp_r) << PAGE_SHIFT);
        res_ord_nxt  = want_r;
        state_nxt    = S_DONE;
      end
      // free: check the block head
      S_R0: begin
        if (start_pg >= 32'(NUM_PAGES)) begin
          res_st_nxt = ST_BADFREE;
          state_nxt  = S_DONE;
        end else begin
          pg_nxt    = CW'(start_pg);
          tag_raddr = start_pg[AW-1:0];
          state_nxt = S_R1;
        end
      end
      S_R1: begin
        if ((tag_rdata < TAG_ALLOC0) || (tag_rdata > TAG_ALLOCN)) begin
          res_st_nxt = ST_BADFREE;
          state_nxt  = S_DONE;
        end else begin
          o_nxt     = OW'(tag_rdata - TAG_ALLOC0);
          state_nxt = S_R2;
        end
      end
      // free: look at the buddy
      S_R2: begin
        tag_raddr = bx[AW-1:0];
        if ((o_r < maxo_r) && (bx < 32'(NUM_PAGES))) begin
          b_nxt     = CW'(bx);
          state_nxt = S_R3;
        end else begin
          state_nxt = S_R5;
        end
      end
      S_R3: begin
        if (tag_rdata == (TAG_FREE0 + TW'(o_r))) begin
          so_nxt    = o_r;
          sp_nxt    = b_r;
          ret_nxt   = S_R4;
          state_nxt = S_U0;
        end else begin
          state_nxt = S_R5;
        end
      end
      S_R4: begin
        tag_we    = 1'b1;
        tag_waddr = b_r[AW-1:0];
        state_nxt = S_R4B;
      end
      S_R4B: begin
        tag_we = 1'b1;
        if (b_r < pg_r) begin
          pg_nxt = b_r;
        end
        o_nxt     = o_r + OW'(1);
        state_nxt = S_R2;
      end
      S_R5: begin
        tag_we    = 1'b1;
        tag_wdata = TAG_FREE0 + TW'(o_r);
        so_nxt    = o_r;
        sp_nxt    = pg_r;
        ret_nxt   = S_R6;
        state_nxt = S_F0;
      end
      S_R6: begin
        res_addr_nxt = ADDR_W'(32'(pg_r) << PAGE_SHIFT);
        res_ord_nxt  = o_r;
        state_nxt    = S_DONE;
      end
      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_addr_nxt  = res_addr_r;
          out_ord_nxt   = res_ord_r;
          state_nxt     = S_IDLE;
        end
      end
      // unlink page sp from list so
      S_U0: begin
        state_nxt = S_U1;
      end
      S_U1: begin
        pr_nxt = rd_prev;
        nx_nxt = rd_next;
        if (rd_prev < NIL) begin
          link_raddr = rd_prev[AW-1:0];
          state_nxt  = S_U2;
        end else begin
          head_nxt[so_r] = rd_next;
          state_nxt      = S_U3;
        end
      end
      S_U2: begin
        link_we    = 1'b1;
        link_waddr = pr_r[AW-1:0];
        link_wdata = {nx_r, rd_prev};
        state_nxt  = S_U3;
      end
      S_U3: begin
        link_raddr = nx_r[AW-1:0];
        if (nx_r < NIL) begin
          state_nxt = S_U4;
        end else begin
          tail_nxt[so_r] = pr_r;
          state_nxt      = ret_r;
        end
      end
      S_U4: begin
        link_we    = 1'b1;
        link_waddr = nx_r[AW-1:0];
        link_wdata = {rd_next, pr_r};
        state_nxt  = ret_r;
      end
      // push page sp at the head of list so
      S_F0: begin
        link_we    = 1'b1;
        link_wdata = {head_r[so_r], NIL};
        link_raddr = head_r[so_r][AW-1:0];
        if (head_r[so_r] < NIL) begin
          state_nxt = S_F1;
        end else begin
          tail_nxt[so_r] = sp_r;
          head_nxt[so_r] = sp_r;
          state_nxt      = ret_r;
        end
      end
      S_F1: begin
        link_we        = 1'b1;
        link_waddr     = head_r[so_r][AW-1:0];
        link_wdata     = {rd_next, sp_r};
        head_nxt[so_r] = sp_r;
        state_nxt      = ret_r;
      end
      // append page sp at the tail of list so
      S_B0: begin
        link_we    = 1'b1;
        link_wdata = {NIL, tail_r[so_r]};
        link_raddr = tail_r[so_r][AW-1:0];
        if (tail_r[so_r] < NIL) begin
          state_nxt = S_B1;
        end else begin
          head_nxt[so_r] = sp_r;
          tail_nxt[so_r] = sp_r;
          state_nxt      = ret_r;
        end
      end
      S_B1: begin
        link_we        = 1'b1;
        link_waddr     = tail_r[so_r][AW-1:0];
        link_wdata     = {sp_r, rd_prev};
        tail_nxt[so_r] = sp_r;
        state_nxt      = ret_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // max_order write, saturated
    if (cfg_we) begin
      maxo_nxt = (32'(cfg_wdata) > ORDER_LIMIT) ? OW'(ORDER_LIMIT) : OW'(cfg_wdata);
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      ret_r       <= S_IDLE;
      pg_r        <= '0;
      maxo_r      <= OW'((MAX_ORDER_RST > ORDER_LIMIT) ? ORDER_LIMIT : MAX_ORDER_RST);
      out_valid_r <= 1'b0;
      for (int k = 0; k <= ORDER_LIMIT; k++) begin
        head_r[k] <= NIL;
        tail_r[k] <= NIL;
      end
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      pg_r        <= pg_nxt;
      maxo_r      <= maxo_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r        <= e_nxt;
    blk_r      <= blk_nxt;
    pb_r       <= pb_nxt;
    sp_r       <= sp_nxt;
    b_r        <= b_nxt;
    pr_r       <= pr_nxt;
    nx_r       <= nx_nxt;
    so_r       <= so_nxt;
    o_r        <= o_nxt;
    want_r     <= want_nxt;
    c_r        <= c_nxt;
    size_r     <= size_nxt;
    start_r    <= start_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    res_ord_r  <= res_ord_nxt;
    out_st_r   <= out_st_nxt;
    out_addr_r <= out_addr_nxt;
    out_ord_r  <= out_ord_nxt;
  end

endmodule

// ===== hdl/buddy_page_allocator_unit.sv =====
// channel   direction  payload
// in_ch     in         req_type, size_bytes, start_addr, end_addr
// out_ch    out        status, block_addr, block_order
// cfg_      in         cfg_we, cfg_wdata (max_order)
//
// one request at a time; the tag and link rams each have one registered read port
// reserve: tags every page in the range; build: walks the pages and carves each free run into blocks
// allocate: splits a larger block once per level, or returns NOFREE with no free block
// free: merges with the buddy once per level, or returns BADFREE for a bad address
// after reset a clearing pass zeroes the tags before in_ch is ready
// a new request is taken while the previous result waits on out_ch
module buddy_page_allocator_unit import bpa_pkg::*; #(
  parameter int NUM_PAGES   = DEF_NUM_PAGES,
  parameter int PAGE_SHIFT  = DEF_PAGE_SHIFT,
  parameter int ORDER_LIMIT = DEF_ORDER_LIMIT
) (
  input  logic               clk,
  input  logic               rst_n,
  bpa_req_if.sink            in_ch,
  bpa_rsp_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [ORDER_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(NUM_PAGES + 1);
  localparam int AW = $clog2(NUM_PAGES);
  localparam int TW = $clog2(2 * ORDER_LIMIT + 4);

  logic          tag_we, link_we;
  logic [AW-1:0] tag_waddr, tag_raddr, link_waddr, link_raddr;
  logic [TW-1:0] tag_wdata, tag_rdata;
  logic [2*CW-1:0] link_wdata, link_rdata;

  // sequencer
  bpa_ctrl #(
    .NUM_PAGES   (NUM_PAGES),
    .PAGE_SHIFT  (PAGE_SHIFT),
    .ORDER_LIMIT (ORDER_LIMIT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .tag_we     (tag_we),
    .tag_waddr  (tag_waddr),
    .tag_wdata  (tag_wdata),
    .tag_raddr  (tag_raddr),
    .tag_rdata  (tag_rdata),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata)
  );

  // page tag table
  bpa_ram #(
    .WIDTH (TW),
    .DEPTH (NUM_PAGES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  // next and prev links of the free lists
  bpa_ram #(
    .WIDTH (2 * CW),
    .DEPTH (NUM_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

endmodule
